[rtl/core/emdc_pkg.sv]
// ----------------------------------------------------------------------------
// emdc_pkg
// Types and constants for the equal-mass disc collision core.
// ----------------------------------------------------------------------------
package emdc_pkg;

  localparam int VEL_W    = 24;
  localparam int DIFF_W   = VEL_W + 1;
  localparam int SPIN_W   = 32;
  localparam int RAD_W    = 23;
  localparam int LOOK_W   = 16;
  localparam int CFG_IDX_W = 2;

  // approach test scale: sign of 2^(LOOK_W+1)*P + t*|w|^2
  localparam int LOOK_SHIFT = LOOK_W + 1;

  localparam logic [RAD_W-1:0]  BALL_RADIUS_RST = 23'd1873;
  localparam logic [LOOK_W-1:0] LOOK_AHEAD_RST  = 16'd655;

  localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_AHEAD  = 2'd1;

  typedef struct packed {
    logic signed [VEL_W-1:0] pos_a_x;
    logic signed [VEL_W-1:0] pos_a_y;
    logic signed [VEL_W-1:0] vel_a_x;
    logic signed [VEL_W-1:0] vel_a_y;
    logic signed [VEL_W-1:0] pos_b_x;
    logic signed [VEL_W-1:0] pos_b_y;
    logic signed [VEL_W-1:0] vel_b_x;
    logic signed [VEL_W-1:0] vel_b_y;
  } emdc_in_t;

  typedef struct packed {
    logic                     collided;
    logic signed [VEL_W-1:0]  new_vel_a_x;
    logic signed [VEL_W-1:0]  new_vel_a_y;
    logic signed [VEL_W-1:0]  new_vel_b_x;
    logic signed [VEL_W-1:0]  new_vel_b_y;
    logic signed [SPIN_W-1:0] spin_a_x;
    logic signed [SPIN_W-1:0] spin_a_y;
    logic signed [SPIN_W-1:0] spin_b_x;
    logic signed [SPIN_W-1:0] spin_b_y;
  } emdc_out_t;

endpackage

[rtl/core/emdc_div.sv]
// ----------------------------------------------------------------------------
// emdc_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// tag that travels alongside. Quotient is QW bits; ovf flags num >= den<<QW.
// ----------------------------------------------------------------------------
module emdc_div #(
  parameter int NW = 74,
  parameter int DW = 50,
  parameter int QW = 26,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] den_out,
  output logic          ovf,
  output logic [TW-1:0] tag_out
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic          v  [0:QW];
  logic [DW-1:0] rm [0:QW];
  logic [DW-1:0] dn [0:QW];
  logic [QW-1:0] nq [0:QW];
  logic          ov [0:QW];
  logic [TW-1:0] tg [0:QW];

  logic [CW-1:0] hi;
  assign hi = CW'(num[NW-1:QW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ov[0] <= hi >= CW'(den);
      rm[0] <= hi[DW-1:0];
      nq[0] <= num[QW-1:0];
      dn[0] <= den;
      tg[0] <= tag;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [DW:0] sh;
    logic [DW:0] df;
    logic        ge;

    assign sh = {rm[i-1], nq[i-1][QW-1]};
    assign df = sh - {1'b0, dn[i-1]};
    assign ge = sh >= {1'b0, dn[i-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[i] <= ge ? df[DW-1:0] : sh[DW-1:0];
        nq[i] <= {nq[i-1][QW-2:0], ge};
        dn[i] <= dn[i-1];
        ov[i] <= ov[i-1];
        tg[i] <= tg[i-1];
      end
    end
  end

  assign out_valid = v[QW];
  assign quo       = nq[QW];
  assign rem       = rm[QW];
  assign den_out   = dn[QW];
  assign ovf       = ov[QW];
  assign tag_out   = tg[QW];

endmodule

[rtl/core/equal_mass_disc_collision_core.sv]
// ----------------------------------------------------------------------------
// equal_mass_disc_collision_core
// Elastic collision response for two equal discs on a plane.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries one disc pair per beat:
// positions and velocities, signed Q8.16. Output channel out_valid/out_ready/
// out_data carries the collided flag, new velocities and rolling spins.
// Config channel cfg_valid/cfg_ready/cfg_data/cfg_index writes ball_radius
// (index 0) or look_ahead_time (index 1); cfg_ready is always high. Write
// config only while no pair is in flight.
// Throughput is one pair per cycle while the skid register is empty. For any
// FRAC_BITS there are 6 arithmetic stages, a 27-stage bit-per-stage projection
// divider, 3 update stages, a 33-stage spin divider and an output stage.
// The pipeline advances as one; a two-entry output (last stage plus a skid
// register) lets in_ready stay high on the cycle a result first stalls. While
// the skid register holds a beat, the pipeline freezes and in_ready is low.
// Reset empties the pipeline and loads radius 1873 and look-ahead 655.
// ----------------------------------------------------------------------------
module equal_mass_disc_collision_core
  import emdc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  emdc_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output emdc_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_data
);

  localparam int PROD_W = 2 * DIFF_W;        // 50
  localparam int P_W    = PROD_W + 1;        // 51
  localparam int SQ_W   = PROD_W;            // 50
  localparam int MAG_W  = VEL_W;             // |d| < 2^24
  localparam int PM_W   = P_W - 1;           // |P| bits
  localparam int PL_W   = PM_W / 2;          // 25
  localparam int PH_W   = PM_W - PL_W;       // 25
  localparam int NUM_W  = PM_W + MAG_W;      // 74
  localparam int TW_W   = SQ_W + LOOK_W;     // 66
  localparam int S_W    = TW_W + 3;          // 69
  localparam int KQ_W   = DIFF_W + 1;        // 26
  localparam int KM_W   = KQ_W + 1;
  localparam int K_W    = KM_W + 1;
  localparam int UPD_W  = K_W + 1;
  localparam int M5_W   = VEL_W + 2;
  localparam int SN_W   = M5_W + FRAC_BITS;
  localparam int SD_W   = RAD_W + 1;
  localparam int VTAG_W = 2 + 4 * VEL_W;

  localparam logic signed [UPD_W-1:0] VMAX = UPD_W'((1 << (VEL_W - 1)) - 1);
  localparam logic signed [UPD_W-1:0] VMIN = -UPD_W'(1 << (VEL_W - 1));
  localparam logic [SPIN_W:0] SPOS = (SPIN_W + 1)'((64'd1 << (SPIN_W - 1)) - 64'd1);
  localparam logic [SPIN_W:0] SNEG = (SPIN_W + 1)'(64'd1 << (SPIN_W - 1));

  // config registers
  logic [RAD_W-1:0]  ball_radius;
  logic [LOOK_W-1:0] look_ahead_time;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ball_radius     <= BALL_RADIUS_RST;
      look_ahead_time <= LOOK_AHEAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BALL_RADIUS: ball_radius     <= cfg_data;
        REG_LOOK_AHEAD:  look_ahead_time <= cfg_data[LOOK_W-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic      en;
  logic      skid_full;
  emdc_out_t skid_data;
  emdc_out_t res;
  logic      s10_v;

  assign en       = !skid_full;
  assign in_ready = en;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [UPD_W-1:0] x);
    logic signed [VEL_W-1:0] r;
    if (x > VMAX) begin
      r = VMAX[VEL_W-1:0];
    end else if (x < VMIN) begin
      r = VMIN[VEL_W-1:0];
    end else begin
      r = x[VEL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] mag_vel(input logic signed [VEL_W-1:0] x);
    logic [VEL_W-1:0] n;
    n = -x;
    return x[VEL_W-1] ? n : x;
  endfunction

  function automatic logic signed [SPIN_W-1:0] spin_fin(
    input logic [SPIN_W-1:0] q,
    input logic [SD_W-1:0]   rm,
    input logic [SD_W-1:0]   dn,
    input logic              ovf,
    input logic              neg,
    input logic              hit
  );
    logic [SPIN_W:0] q1;
    logic [SPIN_W:0] lim;
    logic [SPIN_W:0] m;
    logic [SPIN_W:0] sv;
    q1  = {1'b0, q} + (SPIN_W + 1)'(rm >= dn - rm);
    lim = neg ? SNEG : SPOS;
    m   = (ovf || q1 > lim) ? lim : q1;
    sv  = neg ? -m : m;
    return hit ? sv[SPIN_W-1:0] : '0;
  endfunction

  // stage 1: differences
  logic                     s1_v;
  logic signed [DIFF_W-1:0] s1_dx, s1_dy, s1_wx, s1_wy;
  logic signed [VEL_W-1:0]  s1_vax, s1_vay, s1_vbx, s1_vby;

  // stage 2: products
  logic                     s2_v;
  logic signed [PROD_W-1:0] s2_xx, s2_yy, s2_wdx, s2_wdy, s2_wwx, s2_wwy;
  logic signed [DIFF_W-1:0] s2_dx, s2_dy;
  logic signed [VEL_W-1:0]  s2_vax, s2_vay, s2_vbx, s2_vby;

  // stage 3: sums
  logic                    s3_v;
  logic signed [P_W-1:0]   s3_p;
  logic [SQ_W-1:0]         s3_wsq, s3_r2;
  logic [MAG_W-1:0]        s3_adx, s3_ady;
  logic                    s3_sdx, s3_sdy;
  logic signed [VEL_W-1:0] s3_vax, s3_vay, s3_vbx, s3_vby;

  // stage 4: |P| and t*|w|^2
  logic                    s4_v;
  logic signed [P_W-1:0]   s4_p;
  logic [PM_W-1:0]         s4_ap;
  logic [TW_W-1:0]         s4_tw;
  logic [SQ_W-1:0]         s4_r2;
  logic [MAG_W-1:0]        s4_adx, s4_ady;
  logic                    s4_nx, s4_ny;
  logic signed [VEL_W-1:0] s4_vax, s4_vay, s4_vbx, s4_vby;

  // stage 5: approach test, partial products of |P|*|d|
  logic                     s5_v;
  logic                     s5_hit;
  logic [PL_W+MAG_W-1:0]    s5_plx, s5_ply;
  logic [PH_W+MAG_W-1:0]    s5_phx, s5_phy;
  logic [SQ_W-1:0]          s5_r2;
  logic                     s5_nx, s5_ny;
  logic signed [VEL_W-1:0]  s5_vax, s5_vay, s5_vbx, s5_vby;
  logic signed [S_W-1:0]    s4_sum;
  logic                     s4_sep;

  // stage 6: numerators
  logic                    s6_v;
  logic                    s6_hit;
  logic [NUM_W-1:0]        s6_numx, s6_numy;
  logic [SQ_W-1:0]         s6_r2;
  logic                    s6_nx, s6_ny;
  logic signed [VEL_W-1:0] s6_vax, s6_vay, s6_vbx, s6_vby;

  assign s4_sum = (S_W'(s4_p) <<< LOOK_SHIFT) + $signed({3'b000, s4_tw});
  assign s4_sep = (look_ahead_time != '0) && (s4_sum > 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx  <= DIFF_W'(in_data.pos_a_x) - DIFF_W'(in_data.pos_b_x);
      s1_dy  <= DIFF_W'(in_data.pos_a_y) - DIFF_W'(in_data.pos_b_y);
      s1_wx  <= DIFF_W'(in_data.vel_a_x) - DIFF_W'(in_data.vel_b_x);
      s1_wy  <= DIFF_W'(in_data.vel_a_y) - DIFF_W'(in_data.vel_b_y);
      s1_vax <= in_data.vel_a_x;
      s1_vay <= in_data.vel_a_y;
      s1_vbx <= in_data.vel_b_x;
      s1_vby <= in_data.vel_b_y;

      s2_xx  <= s1_dx * s1_dx;
      s2_yy  <= s1_dy * s1_dy;
      s2_wdx <= s1_wx * s1_dx;
      s2_wdy <= s1_wy * s1_dy;
      s2_wwx <= s1_wx * s1_wx;
      s2_wwy <= s1_wy * s1_wy;
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;
      s2_vax <= s1_vax;
      s2_vay <= s1_vay;
      s2_vbx <= s1_vbx;
      s2_vby <= s1_vby;

      // squares are non-negative and below 2^48
      s3_p   <= P_W'(s2_wdx) + P_W'(s2_wdy);
      s3_wsq <= $unsigned(s2_wwx) + $unsigned(s2_wwy);
      s3_r2  <= $unsigned(s2_xx) + $unsigned(s2_yy);
      s3_adx <= s2_dx[DIFF_W-1] ? MAG_W'(-s2_dx) : MAG_W'(s2_dx);
      s3_ady <= s2_dy[DIFF_W-1] ? MAG_W'(-s2_dy) : MAG_W'(s2_dy);
      s3_sdx <= s2_dx[DIFF_W-1];
      s3_sdy <= s2_dy[DIFF_W-1];
      s3_vax <= s2_vax;
      s3_vay <= s2_vay;
      s3_vbx <= s2_vbx;
      s3_vby <= s2_vby;

      s4_p   <= s3_p;
      s4_ap  <= s3_p[P_W-1] ? PM_W'(-s3_p) : PM_W'(s3_p);
      s4_tw  <= TW_W'(s3_wsq) * TW_W'(look_ahead_time);
      s4_r2  <= s3_r2;
      s4_adx <= s3_adx;
      s4_ady <= s3_ady;
      s4_nx  <= s3_p[P_W-1] ^ s3_sdx;
      s4_ny  <= s3_p[P_W-1] ^ s3_sdy;
      s4_vax <= s3_vax;
      s4_vay <= s3_vay;
      s4_vbx <= s3_vbx;
      s4_vby <= s3_vby;

      s5_hit <= (s4_r2 != '0) && !s4_sep;
      s5_plx <= s4_ap[PL_W-1:0] * s4_adx;
      s5_ply <= s4_ap[PL_W-1:0] * s4_ady;
      s5_phx <= s4_ap[PM_W-1:PL_W] * s4_adx;
      s5_phy <= s4_ap[PM_W-1:PL_W] * s4_ady;
      s5_r2  <= s4_r2;
      s5_nx  <= s4_nx;
      s5_ny  <= s4_ny;
      s5_vax <= s4_vax;
      s5_vay <= s4_vay;
      s5_vbx <= s4_vbx;
      s5_vby <= s4_vby;

      s6_hit  <= s5_hit;
      s6_numx <= {s5_phx, {PL_W{1'b0}}} + NUM_W'(s5_plx);
      s6_numy <= {s5_phy, {PL_W{1'b0}}} + NUM_W'(s5_ply);
      s6_r2   <= s5_r2;
      s6_nx   <= s5_nx;
      s6_ny   <= s5_ny;
      s6_vax  <= s5_vax;
      s6_vay  <= s5_vay;
      s6_vbx  <= s5_vbx;
      s6_vby  <= s5_vby;
    end
  end

  // projection dividers: k = round(|P||d|/r2)
  logic              pd_v;
  logic [KQ_W-1:0]   pdx_q, pdy_q;
  logic [SQ_W-1:0]   pdx_r, pdy_r, pdx_d, pdy_d;
  logic [VTAG_W-1:0] pdx_tag;
  logic              pdy_tag;

  emdc_div #(.NW(NUM_W), .DW(SQ_W), .QW(KQ_W), .TW(VTAG_W)) u_proj_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(s6_v),
    .num(s6_numx), .den(s6_r2),
    .tag({s6_hit, s6_nx, s6_vax, s6_vay, s6_vbx, s6_vby}),
    .out_valid(pd_v), .quo(pdx_q), .rem(pdx_r), .den_out(pdx_d), .ovf(),
    .tag_out(pdx_tag)
  );

  emdc_div #(.NW(NUM_W), .DW(SQ_W), .QW(KQ_W), .TW(1)) u_proj_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(s6_v),
    .num(s6_numy), .den(s6_r2), .tag(s6_ny),
    .out_valid(), .quo(pdy_q), .rem(pdy_r), .den_out(pdy_d), .ovf(),
    .tag_out(pdy_tag)
  );

  // stage 7: signed, rounded k
  logic                    s7_v;
  logic                    s7_hit;
  logic signed [K_W-1:0]   s7_kx, s7_ky;
  logic signed [VEL_W-1:0] s7_vax, s7_vay, s7_vbx, s7_vby;
  logic [KM_W-1:0]         kmx, kmy;

  assign kmx = KM_W'(pdx_q) + KM_W'(pdx_r >= pdx_d - pdx_r);
  assign kmy = KM_W'(pdy_q) + KM_W'(pdy_r >= pdy_d - pdy_r);

  // stage 8: exchanged velocities
  logic                    s8_v;
  logic                    s8_hit;
  logic signed [VEL_W-1:0] s8_vax, s8_vay, s8_vbx, s8_vby;

  // stage 9: spin numerators and divisor
  logic                    s9_v;
  logic [SN_W-1:0]         s9_nax, s9_nay, s9_nbx, s9_nby;
  logic                    s9_gax, s9_gay, s9_gbx, s9_gby;
  logic [SD_W-1:0]         s9_den;
  logic [VTAG_W-2:0]       s9_tag;

  function automatic logic [SN_W-1:0] spin_num(input logic [MAG_W-1:0] m);
    logic [M5_W-1:0] m5;
    m5 = {m, 2'b00} + M5_W'(m);
    return {m5, {FRAC_BITS{1'b0}}};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
      s8_v <= 1'b0;
      s9_v <= 1'b0;
    end else if (en) begin
      s7_v <= pd_v;
      s8_v <= s7_v;
      s9_v <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_hit <= pdx_tag[VTAG_W-1];
      s7_kx  <= pdx_tag[VTAG_W-2] ? -K_W'(kmx) : K_W'(kmx);
      s7_ky  <= pdy_tag ? -K_W'(kmy) : K_W'(kmy);
      s7_vax <= pdx_tag[4*VEL_W-1:3*VEL_W];
      s7_vay <= pdx_tag[3*VEL_W-1:2*VEL_W];
      s7_vbx <= pdx_tag[2*VEL_W-1:VEL_W];
      s7_vby <= pdx_tag[VEL_W-1:0];

      s8_hit <= s7_hit;
      s8_vax <= s7_hit ? sat_vel(UPD_W'(s7_vax) - UPD_W'(s7_kx)) : s7_vax;
      s8_vay <= s7_hit ? sat_vel(UPD_W'(s7_vay) - UPD_W'(s7_ky)) : s7_vay;
      s8_vbx <= s7_hit ? sat_vel(UPD_W'(s7_vbx) + UPD_W'(s7_kx)) : s7_vbx;
      s8_vby <= s7_hit ? sat_vel(UPD_W'(s7_vby) + UPD_W'(s7_ky)) : s7_vby;

      // spin_x uses -vy, spin_y uses vx
      s9_nax <= spin_num(mag_vel(s8_vay));
      s9_nay <= spin_num(mag_vel(s8_vax));
      s9_nbx <= spin_num(mag_vel(s8_vby));
      s9_nby <= spin_num(mag_vel(s8_vbx));
      s9_gax <= !s8_vay[VEL_W-1] && (s8_vay != '0);
      s9_gay <= s8_vax[VEL_W-1];
      s9_gbx <= !s8_vby[VEL_W-1] && (s8_vby != '0);
      s9_gby <= s8_vbx[VEL_W-1];
      s9_den <= {(ball_radius == '0) ? RAD_W'(1) : ball_radius, 1'b0};
      s9_tag <= {s8_hit, s8_vax, s8_vay, s8_vbx, s8_vby};
    end
  end

  // spin dividers: round(5*|v|*2^F / (2r)), quotient saturates at 32 bits
  logic              sd_v;
  logic [SPIN_W-1:0] sax_q, say_q, sbx_q, sby_q;
  logic [SD_W-1:0]   sax_r, say_r, sbx_r, sby_r;
  logic [SD_W-1:0]   sax_d, say_d, sbx_d, sby_d;
  logic              sax_o, say_o, sbx_o, sby_o;
  logic              say_g, sbx_g, sby_g;
  logic [VTAG_W-1:0] sax_tag;
  logic              sax_g;

  emdc_div #(.NW(SN_W), .DW(SD_W), .QW(SPIN_W), .TW(VTAG_W)) u_spin_ax (
    .clk(clk), .rst(rst), .en(en), .in_valid(s9_v),
    .num(s9_nax), .den(s9_den),
    .tag({s9_tag[VTAG_W-2], s9_gax, s9_tag[4*VEL_W-1:0]}),
    .out_valid(sd_v), .quo(sax_q), .rem(sax_r), .den_out(sax_d), .ovf(sax_o),
    .tag_out(sax_tag)
  );

  emdc_div #(.NW(SN_W), .DW(SD_W), .QW(SPIN_W), .TW(1)) u_spin_ay (
    .clk(clk), .rst(rst), .en(en), .in_valid(s9_v),
    .num(s9_nay), .den(s9_den), .tag(s9_gay),
    .out_valid(), .quo(say_q), .rem(say_r), .den_out(say_d), .ovf(say_o),
    .tag_out(say_g)
  );

  emdc_div #(.NW(SN_W), .DW(SD_W), .QW(SPIN_W), .TW(1)) u_spin_bx (
    .clk(clk), .rst(rst), .en(en), .in_valid(s9_v),
    .num(s9_nbx), .den(s9_den), .tag(s9_gbx),
    .out_valid(), .quo(sbx_q), .rem(sbx_r), .den_out(sbx_d), .ovf(sbx_o),
    .tag_out(sbx_g)
  );

  emdc_div #(.NW(SN_W), .DW(SD_W), .QW(SPIN_W), .TW(1)) u_spin_by (
    .clk(clk), .rst(rst), .en(en), .in_valid(s9_v),
    .num(s9_nby), .den(s9_den), .tag(s9_gby),
    .out_valid(), .quo(sby_q), .rem(sby_r), .den_out(sby_d), .ovf(sby_o),
    .tag_out(sby_g)
  );

  assign sax_g = sax_tag[VTAG_W-2];

  // stage 10: rounding, saturation, sign; this is the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (en) begin
      s10_v <= sd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.collided    <= sax_tag[VTAG_W-1];
      res.new_vel_a_x <= sax_tag[4*VEL_W-1:3*VEL_W];
      res.new_vel_a_y <= sax_tag[3*VEL_W-1:2*VEL_W];
      res.new_vel_b_x <= sax_tag[2*VEL_W-1:VEL_W];
      res.new_vel_b_y <= sax_tag[VEL_W-1:0];
      res.spin_a_x    <= spin_fin(sax_q, sax_r, sax_d, sax_o, sax_g, sax_tag[VTAG_W-1]);
      res.spin_a_y    <= spin_fin(say_q, say_r, say_d, say_o, say_g, sax_tag[VTAG_W-1]);
      res.spin_b_x    <= spin_fin(sbx_q, sbx_r, sbx_d, sbx_o, sbx_g, sax_tag[VTAG_W-1]);
      res.spin_b_y    <= spin_fin(sby_q, sby_r, sby_d, sby_o, sby_g, sax_tag[VTAG_W-1]);
    end
  end

  // skid register catches the last stage when the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ready) begin
        skid_full <= 1'b0;
      end
    end else if (s10_v && !out_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && s10_v && !out_ready) begin
      skid_data <= res;
    end
  end

  assign out_valid = skid_full || s10_v;
  assign out_data  = skid_full ? skid_data : res;

`ifndef NO_ASSERTIONS
  a_spin_zero_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.collided |->
      out_data.spin_a_x == '0 && out_data.spin_a_y == '0 &&
      out_data.spin_b_x == '0 && out_data.spin_b_y == '0)
    else $error("spin nonzero on a pass-through result");

  a_skid_load: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(s10_v && !out_ready))
    else $error("skid loaded without a stalled result");

  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");
`endif

endmodule
